@@ rtl/core/hfts_pkg.sv @@
package hfts_pkg;

    // number formats
    localparam int CW              = 32;              // coordinate width, Q16.16
    localparam int FRAC            = 16;              // fraction bits
    localparam int VERTEX_CAPACITY = 16384;
    localparam int ADDR_W          = $clog2(VERTEX_CAPACITY);
    localparam int DIM_W           = 15;              // grid_columns / grid_rows
    localparam int IVL_W           = 31;              // cell_interval
    localparam int LIM_W           = DIM_W + IVL_W;   // grid extent
    localparam int CELL_W          = 2 * DIM_W + 2;   // linear cell index
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = IVL_W;

    // stream packing
    localparam int S_FIELDS_W = ADDR_W + 5 * CW;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((CW + 7) / 8) * 8;

    localparam logic signed [CW-1:0] COORD_MAX       = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] COORD_MIN       = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] OFF_GRID_HEIGHT = CW'(-(5 * (2 ** FRAC)));

    // word kinds on s_tuser
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_COLUMNS  = 2'd0,
        REG_GRID_ROWS     = 2'd1,
        REG_CELL_INTERVAL = 2'd2
    } cfg_reg_t;

    // located word, out of the cell-locate pipeline
    typedef struct packed {
        logic                     valid;
        logic                     op;
        logic                     offgrid;
        logic [ADDR_W-1:0]        addr_c;
        logic [ADDR_W-1:0]        addr_p;   // pivot, or load slot
        logic signed [CW-1:0]     a;        // qx / vertex x
        logic signed [CW-1:0]     b;        // qz / vertex z
        logic signed [CW-1:0]     c;        // vertex height
    } loc_t;

    // corner data read from the vertex stores
    typedef struct packed {
        logic                     valid;
        logic                     offgrid;
        logic signed [CW-1:0]     qx;
        logic signed [CW-1:0]     qz;
        logic signed [CW-1:0]     x_p;
        logic signed [CW-1:0]     x_p1;
        logic signed [CW-1:0]     z_p;
        logic signed [CW-1:0]     z_c;
        logic signed [CW-1:0]     h_p;
        logic signed [CW-1:0]     h_p1;
        logic signed [CW-1:0]     h_c1;
        logic signed [CW-1:0]     h_c;
    } mem_t;

    // what travels beside the ratio dividers
    typedef struct packed {
        logic                     valid;
        logic                     offgrid;
        logic signed [CW-1:0]     h_p;
        logic signed [CW-1:0]     h_p1;
        logic signed [CW-1:0]     h_c1;
        logic signed [CW-1:0]     h_c;
    } side_t;

    typedef struct packed {
        side_t                    side;
        logic signed [CW-1:0]     rx;
        logic signed [CW-1:0]     rz;
    } rat_t;

endpackage

@@ rtl/core/heightfield_triangle_height_sampler.sv @@
// Heightfield triangle height sampler.
//
// Input stream s_*: each word is a load (s_tuser = 0) that writes one vertex
// (x, height, z) into the store slot vertex_index, or a query (s_tuser = 1)
// that asks the terrain height at (query_x, query_z). All values Q16.16.
// Output stream m_*: one word per query, none per load: m_tdata is the
// interpolated height, m_tuser is the in-range flag (height -5.0 when clear).
// Grid size and vertex spacing come from the cfg_* write port; write it only
// while no word is in flight.
//
// Throughput is one word per cycle while the output is not stalled. From acceptance
// to m_tvalid a word passes the cell locate pipeline (one quotient bit per stage of
// the interval divider), the vertex store read, the ratio dividers (one quotient bit
// per stage) and the blend multiply and sum.
// Loads take effect at the store stage, in order with queries around them.
//
// Reset clears all valid bits and sets the grid to 2 x 2 with unit spacing;
// store contents stay undefined until loaded. When m_tready is low with a
// word waiting, the whole pipeline holds and s_tready drops.
module heightfield_triangle_height_sampler import hfts_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // vertex_index, vertex_x, vertex_height, vertex_z, query_x, query_z, pad
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // operation
    input  logic [0:0]            s_tuser,
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // height
    output logic [M_TDATA_W-1:0]  m_tdata,
    // in_range
    output logic [0:0]            m_tuser
);

    localparam int OFS_VX = ADDR_W;
    localparam int OFS_VH = OFS_VX + CW;
    localparam int OFS_VZ = OFS_VH + CW;
    localparam int OFS_QX = OFS_VZ + CW;
    localparam int OFS_QZ = OFS_QX + CW;

    logic [DIM_W-1:0]     cols_reg;
    logic [DIM_W-1:0]     rows_reg;
    logic [IVL_W-1:0]     ivl_reg;
    logic [LIM_W-1:0]     lim_x_reg;
    logic [LIM_W-1:0]     lim_z_reg;
    logic                 degen_reg;
    logic [DIM_W-1:0]     cols_next;
    logic [DIM_W-1:0]     rows_next;
    logic [IVL_W-1:0]     ivl_next;

    logic                 adv;
    logic                 in_op;
    logic signed [CW-1:0] in_a;
    logic signed [CW-1:0] in_b;
    logic signed [CW-1:0] in_c;
    loc_t                 loc_w;
    mem_t                 mem_w;
    rat_t                 rat_w;
    logic                 out_valid;
    logic signed [CW-1:0] out_height;
    logic                 out_in_range;

    // next register values, so the grid extents follow a write at once
    always_comb begin
        cols_next = cols_reg;
        rows_next = rows_reg;
        ivl_next  = ivl_reg;
        if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_GRID_COLUMNS:  cols_next = cfg_wdata[DIM_W-1:0];
                REG_GRID_ROWS:     rows_next = cfg_wdata[DIM_W-1:0];
                REG_CELL_INTERVAL: ivl_next  = cfg_wdata[IVL_W-1:0];
                default: ;
            endcase
        end
    end

    // configuration registers and grid extents
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg  <= DIM_W'(2);
            rows_reg  <= DIM_W'(2);
            ivl_reg   <= IVL_W'(2 ** FRAC);
            lim_x_reg <= LIM_W'(2 ** FRAC);
            lim_z_reg <= LIM_W'(2 ** FRAC);
            degen_reg <= 1'b0;
        end else begin
            cols_reg  <= cols_next;
            rows_reg  <= rows_next;
            ivl_reg   <= ivl_next;
            lim_x_reg <= LIM_W'(cols_next - DIM_W'(1)) * LIM_W'(ivl_next);
            lim_z_reg <= LIM_W'(rows_next - DIM_W'(1)) * LIM_W'(ivl_next);
            degen_reg <= (cols_next < DIM_W'(2)) | (rows_next < DIM_W'(2));
        end
    end

    // whole pipeline moves unless a finished word waits
    assign adv      = ~m_tvalid | m_tready;
    assign s_tready = adv;

    // a load carries its vertex, a query its position
    assign in_op = s_tuser[0];
    assign in_a  = (in_op == OP_QUERY) ? s_tdata[OFS_QX +: CW] : s_tdata[OFS_VX +: CW];
    assign in_b  = (in_op == OP_QUERY) ? s_tdata[OFS_QZ +: CW] : s_tdata[OFS_VZ +: CW];
    assign in_c  = s_tdata[OFS_VH +: CW];

    hfts_locate u_locate (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (s_tvalid),
        .in_op    (in_op),
        .in_idx   (s_tdata[ADDR_W-1:0]),
        .in_a     (in_a),
        .in_b     (in_b),
        .in_c     (in_c),
        .cols     (cols_reg),
        .interval (ivl_reg),
        .lim_x    (lim_x_reg),
        .lim_z    (lim_z_reg),
        .degen    (degen_reg),
        .loc      (loc_w)
    );

    hfts_vmem u_vmem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .loc     (loc_w),
        .mem     (mem_w)
    );

    hfts_ratio u_ratio (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .mem     (mem_w),
        .rat     (rat_w)
    );

    hfts_blend u_blend (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .adv          (adv),
        .rat          (rat_w),
        .out_valid    (out_valid),
        .out_height   (out_height),
        .out_in_range (out_in_range)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = M_TDATA_W'($unsigned(out_height));
    assign m_tuser  = out_in_range;

    // off-grid answers carry the fixed height
    a_offgrid_height: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == M_TDATA_W'($unsigned(OFF_GRID_HEIGHT))))
        else $error("off-grid word without the off-grid height");

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid right after reset");

    // a stalled output word stays put
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("output word changed while stalled");

endmodule

@@ rtl/core/hfts_ram.sv @@
module hfts_ram #(
    parameter int ADDR_BITS = 14,
    parameter int DATA_BITS = 32
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [DATA_BITS-1:0] wdata,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [DATA_BITS-1:0] rdata
);

    logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

    always_ff @(posedge clk) begin
        if (en) begin
            if (we) begin
                mem[waddr] <= wdata;
            end
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/core/hfts_locate.sv @@
module hfts_locate import hfts_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 adv,
    input  logic                 in_valid,
    input  logic                 in_op,
    input  logic [ADDR_W-1:0]    in_idx,
    input  logic signed [CW-1:0] in_a,
    input  logic signed [CW-1:0] in_b,
    input  logic signed [CW-1:0] in_c,
    input  logic [DIM_W-1:0]     cols,
    input  logic [IVL_W-1:0]     interval,
    input  logic [LIM_W-1:0]     lim_x,
    input  logic [LIM_W-1:0]     lim_z,
    input  logic                 degen,
    output loc_t                 loc
);

    localparam int REM_W = CW - 1;

    // stage 0 holds the range check, stages 1..DIM_W one quotient bit each
    logic [DIM_W:0]          dv_valid_reg;
    logic                    dv_op_reg  [DIM_W+1];
    logic                    dv_off_reg [DIM_W+1];
    logic [ADDR_W-1:0]       dv_idx_reg [DIM_W+1];
    logic signed [CW-1:0]    dv_a_reg   [DIM_W+1];
    logic signed [CW-1:0]    dv_b_reg   [DIM_W+1];
    logic signed [CW-1:0]    dv_c_reg   [DIM_W+1];
    logic [REM_W-1:0]        dv_rx_reg  [DIM_W+1];
    logic [REM_W-1:0]        dv_rz_reg  [DIM_W+1];
    logic [DIM_W-1:0]        dv_qx_reg  [DIM_W+1];
    logic [DIM_W-1:0]        dv_qz_reg  [DIM_W+1];

    logic [LIM_W-1:0]        sh_ivl  [DIM_W];
    logic                    ge_x    [DIM_W];
    logic                    ge_z    [DIM_W];
    logic [REM_W-1:0]        rx_next [DIM_W];
    logic [REM_W-1:0]        rz_next [DIM_W];
    logic [DIM_W-1:0]        qx_next [DIM_W];
    logic [DIM_W-1:0]        qz_next [DIM_W];

    logic                    off0;

    // row multiply stage
    logic                    mu_valid_reg;
    logic                    mu_op_reg;
    logic                    mu_off_reg;
    logic [ADDR_W-1:0]       mu_idx_reg;
    logic signed [CW-1:0]    mu_a_reg;
    logic signed [CW-1:0]    mu_b_reg;
    logic signed [CW-1:0]    mu_c_reg;
    logic [CELL_W-1:0]       mu_row_reg;
    logic [DIM_W-1:0]        mu_qx_reg;

    logic [CELL_W-1:0]       cell_idx;
    logic [CELL_W-1:0]       pivot;
    logic                    beyond;
    loc_t                    loc_reg;

    // off the grid: negative, at or past the far edge, or a degenerate grid
    assign off0 = degen | in_a[CW-1] | in_b[CW-1]
                | (LIM_W'($unsigned(in_a)) >= lim_x)
                | (LIM_W'($unsigned(in_b)) >= lim_z);

    // restoring division by the interval, one quotient bit per stage
    always_comb begin
        for (int k = 0; k < DIM_W; k++) begin
            sh_ivl[k]  = LIM_W'(interval) << (DIM_W - 1 - k);
            ge_x[k]    = LIM_W'(dv_rx_reg[k]) >= sh_ivl[k];
            ge_z[k]    = LIM_W'(dv_rz_reg[k]) >= sh_ivl[k];
            rx_next[k] = ge_x[k] ? REM_W'(LIM_W'(dv_rx_reg[k]) - sh_ivl[k]) : dv_rx_reg[k];
            rz_next[k] = ge_z[k] ? REM_W'(LIM_W'(dv_rz_reg[k]) - sh_ivl[k]) : dv_rz_reg[k];
            qx_next[k] = dv_qx_reg[k] | (DIM_W'(ge_x[k]) << (DIM_W - 1 - k));
            qz_next[k] = dv_qz_reg[k] | (DIM_W'(ge_z[k]) << (DIM_W - 1 - k));
        end
    end

    // cell = row * cols + column, pivot one row up
    assign cell_idx = mu_row_reg + CELL_W'(mu_qx_reg);
    assign pivot    = cell_idx + CELL_W'(cols);
    assign beyond   = (pivot + CELL_W'(1)) >= CELL_W'(VERTEX_CAPACITY);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_valid_reg  <= '0;
            mu_valid_reg  <= 1'b0;
            loc_reg.valid <= 1'b0;
        end else if (adv) begin
            dv_valid_reg  <= {dv_valid_reg[DIM_W-1:0], in_valid};
            dv_op_reg[0]  <= in_op;
            dv_off_reg[0] <= off0;
            dv_idx_reg[0] <= in_idx;
            dv_a_reg[0]   <= in_a;
            dv_b_reg[0]   <= in_b;
            dv_c_reg[0]   <= in_c;
            dv_rx_reg[0]  <= in_a[REM_W-1:0];
            dv_rz_reg[0]  <= in_b[REM_W-1:0];
            dv_qx_reg[0]  <= '0;
            dv_qz_reg[0]  <= '0;
            for (int k = 0; k < DIM_W; k++) begin
                dv_op_reg[k+1]  <= dv_op_reg[k];
                dv_off_reg[k+1] <= dv_off_reg[k];
                dv_idx_reg[k+1] <= dv_idx_reg[k];
                dv_a_reg[k+1]   <= dv_a_reg[k];
                dv_b_reg[k+1]   <= dv_b_reg[k];
                dv_c_reg[k+1]   <= dv_c_reg[k];
                dv_rx_reg[k+1]  <= rx_next[k];
                dv_rz_reg[k+1]  <= rz_next[k];
                dv_qx_reg[k+1]  <= qx_next[k];
                dv_qz_reg[k+1]  <= qz_next[k];
            end

            mu_valid_reg <= dv_valid_reg[DIM_W];
            mu_op_reg    <= dv_op_reg[DIM_W];
            mu_off_reg   <= dv_off_reg[DIM_W];
            mu_idx_reg   <= dv_idx_reg[DIM_W];
            mu_a_reg     <= dv_a_reg[DIM_W];
            mu_b_reg     <= dv_b_reg[DIM_W];
            mu_c_reg     <= dv_c_reg[DIM_W];
            mu_row_reg   <= CELL_W'(dv_qz_reg[DIM_W]) * CELL_W'(cols);
            mu_qx_reg    <= dv_qx_reg[DIM_W];

            loc_reg.valid   <= mu_valid_reg;
            loc_reg.op      <= mu_op_reg;
            loc_reg.offgrid <= mu_off_reg | beyond;
            loc_reg.addr_c  <= cell_idx[ADDR_W-1:0];
            loc_reg.addr_p  <= (mu_op_reg == OP_LOAD) ? mu_idx_reg : pivot[ADDR_W-1:0];
            loc_reg.a       <= mu_a_reg;
            loc_reg.b       <= mu_b_reg;
            loc_reg.c       <= mu_c_reg;
        end
    end

    assign loc = loc_reg;

endmodule

@@ rtl/core/hfts_vmem.sv @@
module hfts_vmem import hfts_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic adv,
    input  loc_t loc,
    output mem_t mem
);

    logic                 we;
    logic [ADDR_W-1:0]    addr_p1;
    logic [ADDR_W-1:0]    addr_c1;
    logic [CW-1:0]        rd_x_p, rd_x_p1, rd_z_p, rd_z_c;
    logic [CW-1:0]        rd_h_p, rd_h_p1, rd_h_c1, rd_h_c;

    logic                 valid_reg;
    logic                 off_reg;
    logic signed [CW-1:0] qx_reg;
    logic signed [CW-1:0] qz_reg;

    // a load word writes every copy; the same stage serves the reads of a query
    assign we      = adv & loc.valid & (loc.op == OP_LOAD);
    assign addr_p1 = loc.addr_p + ADDR_W'(1);
    assign addr_c1 = loc.addr_c + ADDR_W'(1);

    // one store copy per read port
    hfts_ram #(.ADDR_BITS(ADDR_W), .DATA_BITS(CW)) u_x_p (
        .clk(aclk), .en(adv), .we(we), .waddr(loc.addr_p), .wdata(loc.a),
        .raddr(loc.addr_p), .rdata(rd_x_p));
    hfts_ram #(.ADDR_BITS(ADDR_W), .DATA_BITS(CW)) u_x_p1 (
        .clk(aclk), .en(adv), .we(we), .waddr(loc.addr_p), .wdata(loc.a),
        .raddr(addr_p1), .rdata(rd_x_p1));
    hfts_ram #(.ADDR_BITS(ADDR_W), .DATA_BITS(CW)) u_z_p (
        .clk(aclk), .en(adv), .we(we), .waddr(loc.addr_p), .wdata(loc.b),
        .raddr(loc.addr_p), .rdata(rd_z_p));
    hfts_ram #(.ADDR_BITS(ADDR_W), .DATA_BITS(CW)) u_z_c (
        .clk(aclk), .en(adv), .we(we), .waddr(loc.addr_p), .wdata(loc.b),
        .raddr(loc.addr_c), .rdata(rd_z_c));
    hfts_ram #(.ADDR_BITS(ADDR_W), .DATA_BITS(CW)) u_h_p (
        .clk(aclk), .en(adv), .we(we), .waddr(loc.addr_p), .wdata(loc.c),
        .raddr(loc.addr_p), .rdata(rd_h_p));
    hfts_ram #(.ADDR_BITS(ADDR_W), .DATA_BITS(CW)) u_h_p1 (
        .clk(aclk), .en(adv), .we(we), .waddr(loc.addr_p), .wdata(loc.c),
        .raddr(addr_p1), .rdata(rd_h_p1));
    hfts_ram #(.ADDR_BITS(ADDR_W), .DATA_BITS(CW)) u_h_c1 (
        .clk(aclk), .en(adv), .we(we), .waddr(loc.addr_p), .wdata(loc.c),
        .raddr(addr_c1), .rdata(rd_h_c1));
    hfts_ram #(.ADDR_BITS(ADDR_W), .DATA_BITS(CW)) u_h_c (
        .clk(aclk), .en(adv), .we(we), .waddr(loc.addr_p), .wdata(loc.c),
        .raddr(loc.addr_c), .rdata(rd_h_c));

    // only query words continue past the store
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= loc.valid & (loc.op == OP_QUERY);
            off_reg   <= loc.offgrid;
            qx_reg    <= loc.a;
            qz_reg    <= loc.b;
        end
    end

    assign mem = '{valid: valid_reg, offgrid: off_reg, qx: qx_reg, qz: qz_reg,
                   x_p: rd_x_p, x_p1: rd_x_p1, z_p: rd_z_p, z_c: rd_z_c,
                   h_p: rd_h_p, h_p1: rd_h_p1, h_c1: rd_h_c1, h_c: rd_h_c};

endmodule

@@ rtl/core/hfts_ratio.sv @@
module hfts_ratio import hfts_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic adv,
    input  mem_t mem,
    output rat_t rat
);

    localparam int UD_W  = CW + 1;          // difference / magnitude
    localparam int RN_W  = UD_W + FRAC;     // dividend with fraction bits
    localparam int RQ_W  = CW - 1;          // quotient bits
    localparam int CMP_W = UD_W + RQ_W;

    typedef struct packed {
        logic            neg;
        logic            dzero;
        logic            ovf;
        logic [UD_W-1:0] ud;
        logic [RN_W-1:0] rem;
        logic [RQ_W-1:0] q;
    } lane_t;

    // lane 0 is ratio x, lane 1 ratio z
    logic signed [UD_W-1:0] d_num_reg [2];
    logic signed [UD_W-1:0] d_den_reg [2];
    side_t                  d_side_reg;
    lane_t                  m_lane_reg [2];
    side_t                  m_side_reg;
    lane_t                  st_lane_reg [RQ_W+1][2];
    side_t                  st_side_reg [RQ_W+1];
    rat_t                   out_reg;

    lane_t                  m_next  [2];
    lane_t                  s0_next [2];
    lane_t                  st_next [RQ_W][2];
    logic [CMP_W-1:0]       shv     [RQ_W][2];
    logic                   ge      [RQ_W][2];
    logic signed [CW-1:0]   res     [2];

    // sign and magnitude of each operand
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            m_next[l].neg   = d_num_reg[l][UD_W-1] ^ d_den_reg[l][UD_W-1];
            m_next[l].dzero = (d_den_reg[l] == '0);
            m_next[l].ovf   = 1'b0;
            m_next[l].ud    = d_den_reg[l][UD_W-1] ? UD_W'(-d_den_reg[l])
                                                   : UD_W'(d_den_reg[l]);
            m_next[l].rem   = RN_W'(d_num_reg[l][UD_W-1] ? UD_W'(-d_num_reg[l])
                                                         : UD_W'(d_num_reg[l]));
            m_next[l].q     = '0;
        end
    end

    // integer part too large to fit, then scale the dividend
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            s0_next[l]     = m_lane_reg[l];
            s0_next[l].ovf = CMP_W'(m_lane_reg[l].rem)
                           >= (CMP_W'(m_lane_reg[l].ud) << (RQ_W - FRAC));
            s0_next[l].rem = m_lane_reg[l].rem << FRAC;
        end
    end

    // one quotient bit per stage, most significant first
    always_comb begin
        for (int k = 0; k < RQ_W; k++) begin
            for (int l = 0; l < 2; l++) begin
                shv[k][l]         = CMP_W'(st_lane_reg[k][l].ud) << (RQ_W - 1 - k);
                ge[k][l]          = CMP_W'(st_lane_reg[k][l].rem) >= shv[k][l];
                st_next[k][l]     = st_lane_reg[k][l];
                st_next[k][l].rem = ge[k][l]
                                  ? RN_W'(CMP_W'(st_lane_reg[k][l].rem) - shv[k][l])
                                  : st_lane_reg[k][l].rem;
                st_next[k][l].q   = st_lane_reg[k][l].q
                                  | (RQ_W'(ge[k][l]) << (RQ_W - 1 - k));
            end
        end
    end

    // divide by zero gives the maximum, overflow saturates by sign
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            if (st_lane_reg[RQ_W][l].dzero) begin
                res[l] = COORD_MAX;
            end else if (st_lane_reg[RQ_W][l].ovf) begin
                res[l] = st_lane_reg[RQ_W][l].neg ? COORD_MIN : COORD_MAX;
            end else if (st_lane_reg[RQ_W][l].neg) begin
                res[l] = -$signed({1'b0, st_lane_reg[RQ_W][l].q});
            end else begin
                res[l] = $signed({1'b0, st_lane_reg[RQ_W][l].q});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_side_reg.valid <= 1'b0;
            m_side_reg.valid <= 1'b0;
            for (int k = 0; k <= RQ_W; k++) begin
                st_side_reg[k].valid <= 1'b0;
            end
            out_reg.side.valid <= 1'b0;
        end else if (adv) begin
            // ratio_x = (qx - x[p]) / (x[p+1] - x[p]); ratio_z = (z[p] - qz) / (z[p] - z[c])
            d_num_reg[0] <= UD_W'(mem.qx) - UD_W'(mem.x_p);
            d_den_reg[0] <= UD_W'(mem.x_p1) - UD_W'(mem.x_p);
            d_num_reg[1] <= UD_W'(mem.z_p) - UD_W'(mem.qz);
            d_den_reg[1] <= UD_W'(mem.z_p) - UD_W'(mem.z_c);
            d_side_reg   <= '{valid: mem.valid, offgrid: mem.offgrid, h_p: mem.h_p,
                              h_p1: mem.h_p1, h_c1: mem.h_c1, h_c: mem.h_c};

            m_lane_reg[0] <= m_next[0];
            m_lane_reg[1] <= m_next[1];
            m_side_reg    <= d_side_reg;

            st_lane_reg[0][0] <= s0_next[0];
            st_lane_reg[0][1] <= s0_next[1];
            st_side_reg[0]    <= m_side_reg;
            for (int k = 0; k < RQ_W; k++) begin
                st_lane_reg[k+1][0] <= st_next[k][0];
                st_lane_reg[k+1][1] <= st_next[k][1];
                st_side_reg[k+1]    <= st_side_reg[k];
            end

            out_reg.side <= st_side_reg[RQ_W];
            out_reg.rx   <= res[0];
            out_reg.rz   <= res[1];
        end
    end

    assign rat = out_reg;

endmodule

@@ rtl/core/hfts_blend.sv @@
module hfts_blend import hfts_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 adv,
    input  rat_t                 rat,
    output logic                 out_valid,
    output logic signed [CW-1:0] out_height,
    output logic                 out_in_range
);

    localparam int DH_W   = CW + 1;              // height difference
    localparam int PR_W   = DH_W + CW;           // product magnitude
    localparam int PM_W   = PR_W - FRAC;         // scaled magnitude
    localparam int TERM_W = PM_W + 1;
    localparam int SUM_W  = TERM_W + 2;

    // b0: triangle pick
    logic                    b0_valid_reg, b0_off_reg;
    logic signed [CW-1:0]    b0_h_reg;
    logic signed [DH_W-1:0]  b0_da_reg, b0_db_reg;
    logic signed [CW-1:0]    b0_ra_reg, b0_rb_reg;
    // b1: sign and magnitude
    logic                    b1_valid_reg, b1_off_reg;
    logic signed [CW-1:0]    b1_h_reg;
    logic                    b1_na_reg, b1_nb_reg;
    logic [DH_W-1:0]         b1_ma_reg, b1_mb_reg;
    logic [CW-1:0]           b1_ra_reg, b1_rb_reg;
    // b2: products
    logic                    b2_valid_reg, b2_off_reg;
    logic signed [CW-1:0]    b2_h_reg;
    logic                    b2_na_reg, b2_nb_reg;
    logic [PR_W-1:0]         b2_pa_reg, b2_pb_reg;
    // b3: scaled signed terms
    logic                    b3_valid_reg, b3_off_reg;
    logic signed [CW-1:0]    b3_h_reg;
    logic signed [TERM_W-1:0] b3_ta_reg, b3_tb_reg;
    // output word
    logic                    o_valid_reg, o_in_range_reg;
    logic signed [CW-1:0]    o_height_reg;

    logic                    sel;
    logic signed [DH_W-1:0]  h_p_x, h_p1_x, h_c1_x, h_c_x;
    logic [PM_W-1:0]         sa, sb;
    logic signed [SUM_W-1:0] sum;
    logic signed [CW-1:0]    sat_sum;

    assign sel    = rat.rx >= rat.rz;
    assign h_p_x  = DH_W'(rat.side.h_p);
    assign h_p1_x = DH_W'(rat.side.h_p1);
    assign h_c1_x = DH_W'(rat.side.h_c1);
    assign h_c_x  = DH_W'(rat.side.h_c);

    // products scaled down by the fraction bits, truncated toward zero
    assign sa = b2_pa_reg[PR_W-1:FRAC];
    assign sb = b2_pb_reg[PR_W-1:FRAC];

    // sum of the base height and both terms, saturated
    assign sum = SUM_W'(b3_h_reg) + SUM_W'(b3_ta_reg) + SUM_W'(b3_tb_reg);
    always_comb begin
        if (sum > SUM_W'(COORD_MAX)) begin
            sat_sum = COORD_MAX;
        end else if (sum < SUM_W'(COORD_MIN)) begin
            sat_sum = COORD_MIN;
        end else begin
            sat_sum = CW'(sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b0_valid_reg <= 1'b0;
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end else if (adv) begin
            // upper triangle when ratio_x >= ratio_z
            b0_valid_reg <= rat.side.valid;
            b0_off_reg   <= rat.side.offgrid;
            b0_h_reg     <= rat.side.h_p;
            b0_da_reg    <= sel ? (h_p1_x - h_p_x) : (h_c_x - h_p_x);
            b0_ra_reg    <= sel ? rat.rx : rat.rz;
            b0_db_reg    <= sel ? (h_c1_x - h_p1_x) : (h_c1_x - h_c_x);
            b0_rb_reg    <= sel ? rat.rz : rat.rx;

            b1_valid_reg <= b0_valid_reg;
            b1_off_reg   <= b0_off_reg;
            b1_h_reg     <= b0_h_reg;
            b1_na_reg    <= b0_da_reg[DH_W-1] ^ b0_ra_reg[CW-1];
            b1_nb_reg    <= b0_db_reg[DH_W-1] ^ b0_rb_reg[CW-1];
            b1_ma_reg    <= b0_da_reg[DH_W-1] ? DH_W'(-b0_da_reg) : DH_W'(b0_da_reg);
            b1_mb_reg    <= b0_db_reg[DH_W-1] ? DH_W'(-b0_db_reg) : DH_W'(b0_db_reg);
            b1_ra_reg    <= b0_ra_reg[CW-1] ? CW'(-b0_ra_reg) : CW'(b0_ra_reg);
            b1_rb_reg    <= b0_rb_reg[CW-1] ? CW'(-b0_rb_reg) : CW'(b0_rb_reg);

            b2_valid_reg <= b1_valid_reg;
            b2_off_reg   <= b1_off_reg;
            b2_h_reg     <= b1_h_reg;
            b2_na_reg    <= b1_na_reg;
            b2_nb_reg    <= b1_nb_reg;
            b2_pa_reg    <= PR_W'(b1_ma_reg) * PR_W'(b1_ra_reg);
            b2_pb_reg    <= PR_W'(b1_mb_reg) * PR_W'(b1_rb_reg);

            b3_valid_reg <= b2_valid_reg;
            b3_off_reg   <= b2_off_reg;
            b3_h_reg     <= b2_h_reg;
            b3_ta_reg    <= b2_na_reg ? -$signed({1'b0, sa}) : $signed({1'b0, sa});
            b3_tb_reg    <= b2_nb_reg ? -$signed({1'b0, sb}) : $signed({1'b0, sb});

            o_valid_reg    <= b3_valid_reg;
            o_in_range_reg <= ~b3_off_reg;
            o_height_reg   <= b3_off_reg ? OFF_GRID_HEIGHT : sat_sum;
        end
    end

    assign out_valid    = o_valid_reg;
    assign out_height   = o_height_reg;
    assign out_in_range = o_in_range_reg;

endmodule
